/* hdl/wusd_pkg.sv */
// Shared types and constants of the write-update sharer directory.
`timescale 1ns / 1ps
`default_nettype none
package wusd_pkg;

	localparam int BLK_W     = 12;
	localparam int SRC_W     = 6;
	localparam int NODES_W   = 7;
	localparam int CFG_DW    = 7;
	localparam int MASK_W    = 64;
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = BLK_W / DIV_BITS;

	typedef enum logic [1:0] {
		REQ_READ_MISS  = 2'd0,
		REQ_WRITE_MISS = 2'd1,
		REQ_WRITE      = 2'd2,
		REQ_WRITEBACK  = 2'd3
	} req_kind_t;

	typedef enum logic {
		CFG_NODE_ID   = 1'b0,
		CFG_NUM_NODES = 1'b1
	} cfg_reg_t;

	// Classified request as it travels from the front to the back.
	typedef struct packed {
		req_kind_t          kind;
		logic [SRC_W-1:0]   src;
		logic [NODES_W-1:0] nn;
		logic               misplaced;
		logic               remote;
	} cls_t;

endpackage
`default_nettype wire

/* hdl/write_update_sharer_directory.sv */
// Path: the front remainder unit works 4 bits per cycle over the 12-bit block number, then pushes
// into the queue, and the back reads the map entry as it pops a request and writes it back, where
// the request changes it, as it registers the result.
// The front takes a new request only while idle or while pushing the last one into the queue.
// After reset the sharer map is cleared one entry per cycle, over all DIR_ENTRIES entries, while
// in_ready stays low; configuration writes are taken throughout.
// Reset: node_id 0, num_nodes 1, no sharers in any entry.
`timescale 1ns / 1ps
`default_nettype none
module write_update_sharer_directory #(
	parameter int DIR_ENTRIES = 4096,
	parameter int MAX_NODES   = 64
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire                           cfg_index,
	input  wire  [wusd_pkg::CFG_DW-1:0]   cfg_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [1:0]                    req_type,
	input  wire  [wusd_pkg::BLK_W-1:0]    block_number,
	input  wire  [wusd_pkg::SRC_W-1:0]    src_id,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [wusd_pkg::MASK_W-1:0]   update_mask,
	output logic                          misplaced,
	output logic                          dropped,
	output logic                          remote_reply
);
	import wusd_pkg::*;

	localparam int IDX_W = $clog2(DIR_ENTRIES);
	localparam int QW    = IDX_W + $bits(cls_t);

	logic             clr_busy;
	logic             push_valid;
	logic             push_ready;
	logic [IDX_W-1:0] push_idx;
	cls_t             push_cls;
	logic             q_valid;
	logic             q_ready;
	logic [QW-1:0]    q_data;
	cls_t             q_cls;

	assign q_cls = cls_t'(q_data[$bits(cls_t)-1:0]);

	wusd_front #(
		.DIR_ENTRIES (DIR_ENTRIES),
		.IDX_W       (IDX_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.block_number (block_number),
		.src_id       (src_id),
		.clr_busy     (clr_busy),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_idx     (push_idx),
		.push_cls     (push_cls)
	);

	wusd_queue #(
		.W (QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  ({push_idx, push_cls}),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_data)
	);

	wusd_back #(
		.DIR_ENTRIES (DIR_ENTRIES),
		.MAX_NODES   (MAX_NODES),
		.IDX_W       (IDX_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.clr_busy     (clr_busy),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_idx        (q_data[QW-1 -: IDX_W]),
		.q_cls        (q_cls),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.update_mask  (update_mask),
		.misplaced    (misplaced),
		.dropped      (dropped),
		.remote_reply (remote_reply)
	);

endmodule
`default_nettype wire

/* hdl/wusd_front.sv */
// Front part: configuration registers, request intake and home/entry remainder.
`timescale 1ns / 1ps
`default_nettype none
module wusd_front #(
	parameter int DIR_ENTRIES = 4096,
	parameter int IDX_W       = 12
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire                            cfg_index,
	input  wire  [wusd_pkg::CFG_DW-1:0]    cfg_data,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [1:0]                     req_type,
	input  wire  [wusd_pkg::BLK_W-1:0]     block_number,
	input  wire  [wusd_pkg::SRC_W-1:0]     src_id,
	input  wire                            clr_busy,
	output logic                           push_valid,
	input  wire                            push_ready,
	output logic [IDX_W-1:0]               push_idx,
	output wusd_pkg::cls_t                 push_cls
);
	import wusd_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	// Entry count clipped to the block range; larger counts never wrap a block number.
	localparam int ENT_D = (DIR_ENTRIES > (1 << BLK_W)) ? (1 << BLK_W) : DIR_ENTRIES;
	localparam int ENT_S = BLK_W + $clog2(ENT_D);
	// Rounded-up reciprocal, exact for every block number of BLK_W bits.
	localparam longint ENT_M = ((longint'(1) << ENT_S) + longint'(ENT_D - 1)) / longint'(ENT_D);
	localparam logic [BLK_W:0] ENT_M_C = (BLK_W+1)'(ENT_M);
	localparam logic [BLK_W:0] ENT_D_C = (BLK_W+1)'(ENT_D);

	front_state_t       state_q;
	logic [1:0]         step_q;
	logic [SRC_W-1:0]   node_id_q;
	logic [NODES_W-1:0] num_nodes_q;
	logic [NODES_W-1:0] nn;
	logic [BLK_W-1:0]   sh_q;
	logic [NODES_W-1:0] hr_q;
	logic [BLK_W-1:0]   ir_q;
	logic [NODES_W-1:0] hr_next;
	logic [BLK_W-1:0]   ir_next;
	logic [BLK_W-1:0]   blk_q;
	logic [BLK_W-1:0]   eq_q;
	logic [BLK_W-1:0]   eq_next;
	logic [2*BLK_W:0]   eq_prod;
	logic [2*BLK_W:0]   ir_prod;
	logic [SRC_W-1:0]   src_q;
	req_kind_t          kind_q;
	logic               remote_q;
	logic [NODES_W-1:0] nn_q;
	logic               accept;

	assign cfg_ready = 1'b1;
	assign nn        = (num_nodes_q == '0) ? NODES_W'(1) : num_nodes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q   <= '0;
			num_nodes_q <= NODES_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_NODE_ID:   node_id_q   <= cfg_data[SRC_W-1:0];
				CFG_NUM_NODES: num_nodes_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	assign in_ready   = !clr_busy && ((state_q == F_IDLE) || ((state_q == F_PUSH) && push_ready));
	assign accept     = in_valid && in_ready;
	assign push_valid = (state_q == F_PUSH);

	// Four restoring steps per cycle on the home remainder, most significant bits first.
	always_comb begin
		logic [NODES_W:0] h;
		h = {1'b0, hr_q};
		for (int j = 0; j < DIV_BITS; j++) begin
			h = {h[NODES_W-1:0], sh_q[BLK_W-1-j]};
			if (h >= {1'b0, nn_q})
				h = h - {1'b0, nn_q};
		end
		hr_next = h[NODES_W-1:0];
	end

	// The quotient by the entry count is taken at intake and the remainder registered in the cycle after.
	always_comb begin
		eq_prod = (2*BLK_W+1)'(block_number) * (2*BLK_W+1)'(ENT_M_C);
		eq_next = BLK_W'(eq_prod >> ENT_S);
		ir_prod = (2*BLK_W+1)'(eq_q) * (2*BLK_W+1)'(ENT_D_C);
		ir_next = blk_q - ir_prod[BLK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else if (accept) begin
			state_q <= F_DIV;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: ;
				F_DIV: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'(DIV_STEPS - 1))
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sh_q     <= block_number;
			blk_q    <= block_number;
			eq_q     <= eq_next;
			hr_q     <= '0;
			ir_q     <= '0;
			src_q    <= src_id;
			kind_q   <= req_kind_t'(req_type);
			remote_q <= (src_id != node_id_q);
			nn_q     <= nn;
		end else if (state_q == F_DIV) begin
			sh_q <= sh_q << DIV_BITS;
			hr_q <= hr_next;
			ir_q <= ir_next;
		end
	end

	always_comb begin
		push_idx            = IDX_W'(ir_q);
		push_cls.kind       = kind_q;
		push_cls.src        = src_q;
		push_cls.nn         = nn_q;
		push_cls.remote     = remote_q;
		push_cls.misplaced  = remote_q && (hr_q != {1'b0, node_id_q});
	end

endmodule
`default_nettype wire

/* hdl/wusd_queue.sv */
// Two-entry request queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module wusd_queue #(
	parameter int W = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          wr_valid,
	output logic         wr_ready,
	input  wire  [W-1:0] wr_data,
	output logic         rd_valid,
	input  wire          rd_ready,
	output logic [W-1:0] rd_data
);
	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         push;
	logic         pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

/* hdl/wusd_back.sv */
// Back part: sharer map memory, read-modify-write and the result register.
`timescale 1ns / 1ps
`default_nettype none
module wusd_back #(
	parameter int DIR_ENTRIES = 4096,
	parameter int MAX_NODES   = 64,
	parameter int IDX_W       = 12
) (
	input  wire                           clk,
	input  wire                           arst_n,
	output logic                          clr_busy,
	input  wire                           q_valid,
	output logic                          q_ready,
	input  wire  [IDX_W-1:0]              q_idx,
	input  wire  wusd_pkg::cls_t          q_cls,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [wusd_pkg::MASK_W-1:0]   update_mask,
	output logic                          misplaced,
	output logic                          dropped,
	output logic                          remote_reply
);
	import wusd_pkg::*;

	typedef enum logic [2:0] {
		B_CLEAR = 3'b001,
		B_IDLE  = 3'b010,
		B_MOD   = 3'b100
	} back_state_t;

	logic [MAX_NODES-1:0] mem [DIR_ENTRIES];

	back_state_t          state_q;
	logic [IDX_W-1:0]     clr_addr_q;
	logic [IDX_W-1:0]     idx_q;
	cls_t                 cls_q;
	logic [MAX_NODES-1:0] rd_q;
	logic                 pop;
	logic                 go;
	logic [MAX_NODES-1:0] src_bit;
	logic [MAX_NODES-1:0] lim_mask;
	logic [MAX_NODES-1:0] upd_all;
	logic [MAX_NODES-1:0] new_map;
	logic [MAX_NODES-1:0] upd;
	logic                 we;
	logic                 drop;
	logic                 reply;
	logic                 out_valid_q;

	assign clr_busy  = (state_q == B_CLEAR);
	assign q_ready   = (state_q == B_IDLE);
	assign pop       = q_valid && q_ready;
	assign go        = (state_q == B_MOD) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		for (int i = 0; i < MAX_NODES; i++) begin
			src_bit[i]  = (cls_q.src == SRC_W'(i));
			lim_mask[i] = (NODES_W'(i) < cls_q.nn);
		end
		upd_all = rd_q & ~src_bit & lim_mask;
		new_map = rd_q;
		upd     = '0;
		we      = 1'b1;
		drop    = 1'b0;
		reply   = cls_q.remote;
		unique case (cls_q.kind)
			REQ_READ_MISS: new_map = rd_q | src_bit;
			REQ_WRITE_MISS: begin
				upd     = upd_all;
				new_map = rd_q | src_bit;
			end
			REQ_WRITE: begin
				we = 1'b0;
				if (cls_q.misplaced) begin
					drop  = 1'b1;
					reply = 1'b0;
				end else begin
					upd = upd_all;
				end
			end
			REQ_WRITEBACK: begin
				new_map = rd_q & ~src_bit;
				reply   = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				B_CLEAR: begin
					clr_addr_q <= clr_addr_q + IDX_W'(1);
					if (clr_addr_q == IDX_W'(DIR_ENTRIES - 1))
						state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (pop)
						state_q <= B_MOD;
				end
				B_MOD: begin
					if (go)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// The map is written only after its read completes, so one request never sees stale data.
	always_ff @(posedge clk) begin
		if (state_q == B_CLEAR)
			mem[clr_addr_q] <= '0;
		else if (go && we)
			mem[idx_q] <= new_map;
		if (pop)
			rd_q <= mem[q_idx];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_q <= q_idx;
			cls_q <= q_cls;
		end
		if (go) begin
			update_mask  <= MASK_W'(upd);
			misplaced    <= cls_q.misplaced;
			dropped      <= drop;
			remote_reply <= reply;
		end
	end

endmodule
`default_nettype wire
